// File: design/softmax_probability_unit_assert.svh
`ifndef SOFTMAX_PROBABILITY_UNIT_ASSERT_SVH
`define SOFTMAX_PROBABILITY_UNIT_ASSERT_SVH

// Checks an implication in the same cycle, outside reset.
`define SFMX_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("softmax port check failed");

// Checks an implication in the following cycle, outside reset.
`define SFMX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("softmax port check failed");

// Checks a condition at every edge, reset included.
`define SFMX_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) (cond)) \
		else $error("softmax port check failed");

`endif

// File: design/sfmx_pkg.sv
package sfmx_pkg;

	localparam int MAX_CLASSES = 32;
	localparam int IDX_W = $clog2(MAX_CLASSES);
	localparam int CNT_W = $clog2(MAX_CLASSES + 1);
	localparam int ADDR_W = IDX_W + 1;
	localparam int RAM_DEPTH = 2 * (1 << IDX_W);
	localparam int SUM_W = $clog2(MAX_CLASSES * 65536 + 1);
	localparam int EXP_BITS = 15;
	localparam int EXP_LIMIT = 16384;
	localparam int E_W = 17;
	localparam int NUM_W = E_W + 16;
	localparam int DIV_STEPS = NUM_W;
	localparam int MUL_LAST = 5;
	localparam logic [63:0] Q62_ONE = 64'd1 << 62;

	typedef logic [63:0] exp_tab_t [EXP_BITS];

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		prod = prod + (128'd1 << 61);
		return prod[125:62];
	endfunction

	function automatic exp_tab_t build_exp_tab();
		logic [63:0] term;
		logic [63:0] acc;
		exp_tab_t tab;
		term = Q62_ONE;
		acc = Q62_ONE;
		term = (term >> 10) / 64'd1;
		acc = acc - term;
		term = (term >> 10) / 64'd2;
		acc = acc + term;
		term = (term >> 10) / 64'd3;
		acc = acc - term;
		term = (term >> 10) / 64'd4;
		acc = acc + term;
		term = (term >> 10) / 64'd5;
		acc = acc - term;
		term = (term >> 10) / 64'd6;
		acc = acc + term;
		term = (term >> 10) / 64'd7;
		acc = acc - term;
		term = (term >> 10) / 64'd8;
		acc = acc + term;
		tab[0] = acc;
		for (int i = 1; i < EXP_BITS; i++) begin
			tab[i] = mul_q62(tab[i-1], tab[i-1]);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	typedef struct packed {
		logic bank;
		logic [CNT_W-1:0] count;
		logic signed [15:0] peak;
	} job_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef enum logic [1:0] {EX_IDLE, EX_SCAN, EX_MUL, EX_DONE} ex_state_t;

	typedef enum logic [2:0] {BK_IDLE, BK_READ, BK_WAIT, BK_EXP, BK_DIV, BK_OUT} bk_state_t;

endpackage

// File: design/sfmx_ram.sv
module sfmx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: design/sfmx_queue.sv
module sfmx_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sfmx_pkg::job_t job_in,
	input  logic           pop,
	output sfmx_pkg::job_t job_out,
	output logic           full,
	output logic           empty
);

	sfmx_pkg::job_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] level_q;

	assign full = level_q == 2'd2;
	assign empty = level_q == 2'd0;
	assign job_out = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				level_q <= level_q + 2'd1;
			end else if (pop && !push) begin
				level_q <= level_q - 2'd1;
			end
		end
	end

endmodule

// File: design/sfmx_front.sv
module sfmx_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [15:0]           score,
	input  logic                         last_in,
	input  logic                         score_valid,
	output logic                         score_stall,
	output logic                         wr_en,
	output logic [sfmx_pkg::ADDR_W-1:0]  wr_addr,
	output logic [15:0]                  wr_data,
	output logic                         push,
	output sfmx_pkg::job_t               job,
	input  logic                         queue_full,
	input  sfmx_pkg::release_t           rel
);

	logic bank_q;
	logic [1:0] busy_q;
	logic [1:0] busy_d;
	logic [sfmx_pkg::CNT_W-1:0] count_q;
	logic signed [15:0] peak_q;
	logic accept;
	logic room;
	logic [sfmx_pkg::CNT_W-1:0] count_n;
	logic signed [15:0] peak_n;

	assign score_stall = busy_q[bank_q] || queue_full;
	assign accept = score_valid && !score_stall;
	assign room = count_q < sfmx_pkg::CNT_W'(sfmx_pkg::MAX_CLASSES);
	assign count_n = room ? count_q + 1'b1 : count_q;
	assign peak_n = (room && score > peak_q) ? score : peak_q;

	assign wr_en = accept && room;
	assign wr_addr = {bank_q, count_q[sfmx_pkg::IDX_W-1:0]};
	assign wr_data = score;
	assign push = accept && last_in;
	assign job = '{bank: bank_q, count: count_n, peak: peak_n};

	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (accept && last_in) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			busy_q <= 2'b00;
			count_q <= '0;
			peak_q <= 16'sh8000;
		end else begin
			busy_q <= busy_d;
			if (accept) begin
				if (last_in) begin
					bank_q <= ~bank_q;
					count_q <= '0;
					peak_q <= 16'sh8000;
				end else begin
					count_q <= count_n;
					peak_q <= peak_n;
				end
			end
		end
	end

endmodule

// File: design/sfmx_exp.sv
module sfmx_exp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] delta,
	output logic        done,
	output logic [sfmx_pkg::E_W-1:0] e
);

	sfmx_pkg::ex_state_t state_q, state_d;
	logic [15:0] n_q;
	logic [63:0] p_q;
	logic [3:0] k_q;
	logic [2:0] c_q;
	logic [127:0] acc_q;
	logic [63:0] prod_q;
	logic [1:0] sh_q;
	logic zero_q;
	logic [63:0] tab_word;
	logic [31:0] a_part;
	logic [31:0] b_part;
	logic [127:0] shifted;
	logic [127:0] round62;
	logic [63:0] round46;
	logic scan_end;

	assign scan_end = k_q == 4'(sfmx_pkg::EXP_BITS);
	assign tab_word = sfmx_pkg::EXP_TAB[k_q];
	assign a_part = c_q[1] ? p_q[63:32] : p_q[31:0];
	assign b_part = (c_q[1:0] == 2'd1 || c_q[1:0] == 2'd3) ? tab_word[63:32] : tab_word[31:0];
	assign round62 = acc_q + (128'd1 << 61);
	assign round46 = p_q + (64'd1 << 45);

	always_comb begin
		unique case (sh_q)
			2'd0: shifted = {64'd0, prod_q};
			2'd1, 2'd2: shifted = {32'd0, prod_q, 32'd0};
			default: shifted = {prod_q, 64'd0};
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfmx_pkg::EX_IDLE: begin
				if (start) begin
					state_d = (delta > 16'(sfmx_pkg::EXP_LIMIT)) ? sfmx_pkg::EX_DONE
						: sfmx_pkg::EX_SCAN;
				end
			end
			sfmx_pkg::EX_SCAN: begin
				if (scan_end) begin
					state_d = sfmx_pkg::EX_DONE;
				end else if (n_q[k_q]) begin
					state_d = sfmx_pkg::EX_MUL;
				end
			end
			sfmx_pkg::EX_MUL: begin
				if (c_q == 3'(sfmx_pkg::MUL_LAST)) begin
					state_d = sfmx_pkg::EX_SCAN;
				end
			end
			default: state_d = sfmx_pkg::EX_IDLE;
		endcase
	end

	always_comb begin
		done = state_q == sfmx_pkg::EX_DONE;
		e = zero_q ? '0 : round46[62:46];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfmx_pkg::EX_IDLE;
			c_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sfmx_pkg::EX_MUL) begin
				c_q <= c_q + 3'd1;
			end else begin
				c_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sfmx_pkg::EX_IDLE: begin
				if (start) begin
					n_q <= delta;
					p_q <= sfmx_pkg::Q62_ONE;
					k_q <= '0;
					zero_q <= delta > 16'(sfmx_pkg::EXP_LIMIT);
				end
			end
			sfmx_pkg::EX_SCAN: begin
				if (!scan_end) begin
					if (n_q[k_q]) begin
						acc_q <= '0;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
			end
			sfmx_pkg::EX_MUL: begin
				if (c_q < 3'd4) begin
					prod_q <= {32'd0, a_part} * {32'd0, b_part};
					sh_q <= c_q[1:0];
				end
				if (c_q >= 3'd1 && c_q <= 3'd4) begin
					acc_q <= acc_q + shifted;
				end
				if (c_q == 3'(sfmx_pkg::MUL_LAST)) begin
					p_q <= round62[125:62];
					k_q <= k_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: design/sfmx_back.sv
module sfmx_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  sfmx_pkg::job_t              job,
	output logic                        job_pop,
	output logic [sfmx_pkg::ADDR_W-1:0] rd_addr,
	input  logic [15:0]                 rd_data,
	output sfmx_pkg::release_t          rel,
	output logic [4:0]                  class_index,
	output logic [15:0]                 probability,
	output logic                        last_out,
	output logic                        prob_valid,
	input  logic                        prob_stall
);

	sfmx_pkg::bk_state_t state_q, state_d;
	sfmx_pkg::job_t job_q;
	logic [sfmx_pkg::CNT_W-1:0] idx_q;
	logic pass_q;
	logic [sfmx_pkg::SUM_W-1:0] sum_q;
	logic [sfmx_pkg::SUM_W-1:0] rem_q;
	logic [sfmx_pkg::NUM_W-1:0] num_q;
	logic [5:0] dcnt_q;
	logic exp_start;
	logic exp_done;
	logic [sfmx_pkg::E_W-1:0] exp_e;
	logic [16:0] diff;
	logic [sfmx_pkg::SUM_W:0] trial;
	logic fits;
	logic is_last;
	logic out_free;
	logic [15:0] quot;

	assign diff = {job_q.peak[15], job_q.peak} - {rd_data[15], rd_data};
	assign trial = {rem_q, num_q[sfmx_pkg::NUM_W-1]};
	assign fits = trial >= {1'b0, sum_q};
	assign is_last = idx_q == job_q.count - 1'b1;
	assign out_free = !prob_valid || !prob_stall;
	assign quot = (num_q[sfmx_pkg::NUM_W-1:16] != '0) ? 16'hFFFF : num_q[15:0];
	assign rd_addr = {job_q.bank, idx_q[sfmx_pkg::IDX_W-1:0]};

	sfmx_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.delta  (diff[15:0]),
		.done   (exp_done),
		.e      (exp_e)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfmx_pkg::BK_IDLE: begin
				if (job_valid) begin
					state_d = sfmx_pkg::BK_READ;
				end
			end
			sfmx_pkg::BK_READ: state_d = sfmx_pkg::BK_WAIT;
			sfmx_pkg::BK_WAIT: state_d = sfmx_pkg::BK_EXP;
			sfmx_pkg::BK_EXP: begin
				if (exp_done) begin
					state_d = pass_q ? sfmx_pkg::BK_DIV : sfmx_pkg::BK_READ;
				end
			end
			sfmx_pkg::BK_DIV: begin
				if (dcnt_q == 6'(sfmx_pkg::DIV_STEPS - 1)) begin
					state_d = sfmx_pkg::BK_OUT;
				end
			end
			sfmx_pkg::BK_OUT: begin
				if (out_free) begin
					state_d = is_last ? sfmx_pkg::BK_IDLE : sfmx_pkg::BK_READ;
				end
			end
			default: state_d = sfmx_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop = state_q == sfmx_pkg::BK_IDLE && job_valid;
		exp_start = state_q == sfmx_pkg::BK_WAIT;
		rel.valid = state_q == sfmx_pkg::BK_OUT && out_free && is_last;
		rel.bank = job_q.bank;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfmx_pkg::BK_IDLE;
			prob_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sfmx_pkg::BK_OUT && out_free) begin
				prob_valid <= 1'b1;
			end else if (!prob_stall) begin
				prob_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sfmx_pkg::BK_IDLE: begin
				if (job_valid) begin
					job_q <= job;
					idx_q <= '0;
					pass_q <= 1'b0;
					sum_q <= '0;
				end
			end
			sfmx_pkg::BK_EXP: begin
				if (exp_done) begin
					if (!pass_q) begin
						sum_q <= sum_q + sfmx_pkg::SUM_W'(exp_e);
						if (is_last) begin
							pass_q <= 1'b1;
							idx_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						rem_q <= '0;
						num_q <= {exp_e, 16'd0};
						dcnt_q <= '0;
					end
				end
			end
			sfmx_pkg::BK_DIV: begin
				rem_q <= fits ? sfmx_pkg::SUM_W'(trial - {1'b0, sum_q})
					: trial[sfmx_pkg::SUM_W-1:0];
				num_q <= {num_q[sfmx_pkg::NUM_W-2:0], fits};
				dcnt_q <= dcnt_q + 6'd1;
			end
			sfmx_pkg::BK_OUT: begin
				if (out_free) begin
					class_index <= 5'(idx_q);
					probability <= quot;
					last_out <= is_last;
					idx_q <= idx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: design/softmax_probability_unit.sv
// Scores are taken one per cycle while score_stall is low; the request marked last closes a set of n classes.
// Each stored score is walked twice, once for the sum and once for the divide. A walk
// reads the score and takes the exponential of its distance to the maximum, with one
// multiply for each set bit of the distance, or gives zero when the distance exceeds
// 16384; in the divide walk each class is then divided and output. Two banks let the next set load.
// Reset is asynchronous and active low; it empties the set, the queue and the output.
module softmax_probability_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] score,
	input  logic               last_in,
	input  logic               score_valid,
	output logic               score_stall,
	output logic [4:0]         class_index,
	output logic [15:0]        probability,
	output logic               last_out,
	output logic               prob_valid,
	input  logic               prob_stall
);

	logic wr_en;
	logic [sfmx_pkg::ADDR_W-1:0] wr_addr;
	logic [15:0] wr_data;
	logic [sfmx_pkg::ADDR_W-1:0] rd_addr;
	logic [15:0] rd_data;
	logic push;
	logic pop;
	logic queue_full;
	logic queue_empty;
	sfmx_pkg::job_t job_in;
	sfmx_pkg::job_t job_out;
	sfmx_pkg::release_t rel;

	sfmx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.score       (score),
		.last_in     (last_in),
		.score_valid (score_valid),
		.score_stall (score_stall),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.push        (push),
		.job         (job_in),
		.queue_full  (queue_full),
		.rel         (rel)
	);

	sfmx_ram #(
		.WIDTH (16),
		.DEPTH (sfmx_pkg::RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sfmx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.job_out (job_out),
		.full    (queue_full),
		.empty   (queue_empty)
	);

	sfmx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (!queue_empty),
		.job         (job_out),
		.job_pop     (pop),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.rel         (rel),
		.class_index (class_index),
		.probability (probability),
		.last_out    (last_out),
		.prob_valid  (prob_valid),
		.prob_stall  (prob_stall)
	);

endmodule

// File: design/sfmx_checker.sv
`include "softmax_probability_unit_assert.svh"

module sfmx_checker (
	input logic               clk,
	input logic               arst_n,
	input logic [4:0]         class_index,
	input logic [15:0]        probability,
	input logic               last_out,
	input logic               prob_valid,
	input logic               prob_stall
);

	// A stalled probability keeps its payload.
	`SFMX_ASSERT_NEXT(a_hold_data, prob_valid && prob_stall, $stable(class_index) && $stable(probability) && $stable(last_out))
	// A set of one class always gets the saturated full probability.
	`SFMX_ASSERT_SAME(a_one_class, prob_valid && last_out && class_index == '0, &probability)
	// A stalled probability stays offered.
	`SFMX_ASSERT_NEXT(a_hold_valid, prob_valid && prob_stall, prob_valid)
	// No probability is offered while reset is applied.
	`SFMX_ASSERT_ALWAYS(a_reset_quiet, arst_n || !prob_valid)

endmodule

bind softmax_probability_unit sfmx_checker u_sfmx_checker (.*);
